[rtl/pu_pkg.sv]
// package for the permutation unranking block: types, widths and factorial table
package pu_pkg;

  localparam int unsigned MAX_ELEMENTS = 10;
  localparam int unsigned RANK_W       = 22;
  localparam int unsigned ELEM_W       = 4;
  localparam int unsigned CNT_W        = 4;
  localparam int unsigned IDX_W        = $clog2(MAX_ELEMENTS);
  // quotient digits per position; the quotient stays below MAX_ELEMENTS
  localparam int unsigned QBITS        = 4;
  localparam int unsigned BIT_W        = $clog2(QBITS);
  // width of the shared compare/subtract unit, room for the shifted divisor
  localparam int unsigned CMP_W        = RANK_W + QBITS - 1;

  localparam logic [CNT_W-1:0] MIN_COUNT   = CNT_W'(2);
  localparam logic [CNT_W-1:0] MAX_COUNT   = CNT_W'(MAX_ELEMENTS);
  localparam logic [CNT_W-1:0] RESET_COUNT = CNT_W'(10);

  // factorials 0! .. 10!, unused codes read as zero
  localparam logic [RANK_W-1:0] FACT [16] = '{
    22'd1, 22'd1, 22'd2, 22'd6, 22'd24, 22'd120, 22'd720, 22'd5040,
    22'd40320, 22'd362880, 22'd3628800, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0
  };

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIVIDE,
    S_EMIT,
    S_BAD
  } state_e;

  // result of the shared compare/subtract unit
  typedef struct packed {
    logic             ge;
    logic [CMP_W-1:0] diff;
  } cmp_res_t;

endpackage

[rtl/pu_cmp_sub.sv]
// shared compare and subtract unit: a >= b flag and a - b
module pu_cmp_sub (
  input  logic [pu_pkg::CMP_W-1:0] a_i,
  input  logic [pu_pkg::CMP_W-1:0] b_i,
  output pu_pkg::cmp_res_t         res_o
);

  logic [pu_pkg::CMP_W:0] sub;

  // one wide subtract, borrow gives the compare
  assign sub        = {1'b0, a_i} - {1'b0, b_i};
  assign res_o.ge   = ~sub[pu_pkg::CMP_W];
  assign res_o.diff = sub[pu_pkg::CMP_W-1:0];

endmodule

[rtl/permutation_unrank_top.sv]
// top level of the lexicographic permutation unranking block
// each element is picked by restoring division, one quotient step per cycle in the
//   shared compare/subtract unit; a new rank is stalled until the previous one is done
// a rank at or above n! gives one flagged result instead of elements
// output stalls hold the sequencer; reset (rst_ni low, async) idles it and sets count to 10
module permutation_unrank_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // rank transactions
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [pu_pkg::RANK_W-1:0]  rank_i,
  // element transactions
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [pu_pkg::ELEM_W-1:0]  element_o,
  output logic                       last_o,
  output logic                       bad_rank_o,
  // configuration write
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [pu_pkg::CNT_W-1:0]   cfg_element_count_i
);

  pu_pkg::state_e                state_q, state_d;
  logic [pu_pkg::CNT_W-1:0]      count_q;
  logic [pu_pkg::RANK_W-1:0]     r_q, r_d;
  logic [pu_pkg::CNT_W-1:0]      n_q, n_d;
  logic [pu_pkg::CNT_W-1:0]      left_q, left_d;
  logic [pu_pkg::QBITS-1:0]      q_q, q_d;
  logic [pu_pkg::BIT_W-1:0]      bit_q, bit_d;
  logic [pu_pkg::ELEM_W-1:0]     pool_q [pu_pkg::MAX_ELEMENTS];
  logic [pu_pkg::ELEM_W-1:0]     pool_d [pu_pkg::MAX_ELEMENTS];
  logic                          out_valid_q, out_valid_d;
  logic [pu_pkg::ELEM_W-1:0]     element_q, element_d;
  logic                          last_q, last_d;
  logic                          bad_q, bad_d;

  logic                          in_accept;
  logic                          slot_free;
  logic [pu_pkg::CNT_W-1:0]      eff_count;
  logic [pu_pkg::CNT_W-1:0]      left_m1;
  logic [pu_pkg::IDX_W-1:0]      qi;
  logic [pu_pkg::CMP_W-1:0]      cmp_a, cmp_b;
  pu_pkg::cmp_res_t              cmp_res;

  assign in_accept   = in_valid_i && !in_stall_o;
  assign slot_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != pu_pkg::S_IDLE);
  assign cfg_ready_o = (state_q == pu_pkg::S_IDLE);

  assign out_valid_o = out_valid_q;
  assign element_o   = element_q;
  assign last_o      = last_q;
  assign bad_rank_o  = bad_q;

  // clamp the register into the supported element range
  always_comb begin
    eff_count = count_q;
    if (count_q < pu_pkg::MIN_COUNT) eff_count = pu_pkg::MIN_COUNT;
    if (count_q > pu_pkg::MAX_COUNT) eff_count = pu_pkg::MAX_COUNT;
  end

  assign left_m1 = left_q - pu_pkg::CNT_W'(1);

  // pick index, clamped below the number of elements left
  always_comb begin
    if (q_q >= left_q) qi = pu_pkg::IDX_W'(left_m1);
    else               qi = pu_pkg::IDX_W'(q_q);
  end

  // operand select for the shared unit: n! range check or shifted divisor
  assign cmp_a = pu_pkg::CMP_W'(r_q);
  always_comb begin
    if (state_q == pu_pkg::S_CHECK) begin
      cmp_b = pu_pkg::CMP_W'(pu_pkg::FACT[n_q]);
    end else begin
      cmp_b = pu_pkg::CMP_W'(pu_pkg::FACT[left_m1]) << bit_q;
    end
  end

  pu_cmp_sub u_cmp_sub (
    .a_i   (cmp_a),
    .b_i   (cmp_b),
    .res_o (cmp_res)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      pu_pkg::S_IDLE: begin
        if (in_accept) state_d = pu_pkg::S_CHECK;
      end
      pu_pkg::S_CHECK: begin
        if (cmp_res.ge) state_d = pu_pkg::S_BAD;
        else            state_d = pu_pkg::S_DIVIDE;
      end
      pu_pkg::S_DIVIDE: begin
        if (bit_q == '0) state_d = pu_pkg::S_EMIT;
      end
      pu_pkg::S_EMIT: begin
        if (slot_free) begin
          if (left_q == pu_pkg::CNT_W'(1)) state_d = pu_pkg::S_IDLE;
          else                             state_d = pu_pkg::S_DIVIDE;
        end
      end
      pu_pkg::S_BAD: begin
        if (slot_free) state_d = pu_pkg::S_IDLE;
      end
      default: state_d = pu_pkg::S_IDLE;
    endcase
  end

  // datapath and output register updates
  always_comb begin
    r_d         = r_q;
    n_d         = n_q;
    left_d      = left_q;
    q_d         = q_q;
    bit_d       = bit_q;
    pool_d      = pool_q;
    out_valid_d = out_valid_q && out_stall_i;
    element_d   = element_q;
    last_d      = last_q;
    bad_d       = bad_q;
    case (state_q)
      pu_pkg::S_IDLE: begin
        if (in_accept) begin
          r_d    = rank_i;
          n_d    = eff_count;
          left_d = eff_count;
          for (int i = 0; i < pu_pkg::MAX_ELEMENTS; i++) begin
            pool_d[i] = pu_pkg::ELEM_W'(i);
          end
        end
      end
      pu_pkg::S_CHECK: begin
        q_d   = '0;
        bit_d = pu_pkg::BIT_W'(pu_pkg::QBITS - 1);
      end
      pu_pkg::S_DIVIDE: begin
        // one restoring quotient bit per cycle
        if (cmp_res.ge) begin
          r_d        = cmp_res.diff[pu_pkg::RANK_W-1:0];
          q_d[bit_q] = 1'b1;
        end
        bit_d = bit_q - pu_pkg::BIT_W'(1);
      end
      pu_pkg::S_EMIT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          element_d   = pool_q[qi];
          last_d      = (left_q == pu_pkg::CNT_W'(1));
          bad_d       = 1'b0;
          // close the gap left by the picked element
          for (int i = 0; i < pu_pkg::MAX_ELEMENTS - 1; i++) begin
            if (pu_pkg::IDX_W'(i) >= qi) pool_d[i] = pool_q[i+1];
          end
          left_d = left_m1;
          q_d    = '0;
          bit_d  = pu_pkg::BIT_W'(pu_pkg::QBITS - 1);
        end
      end
      pu_pkg::S_BAD: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          element_d   = '0;
          last_d      = 1'b1;
          bad_d       = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pu_pkg::S_IDLE;
      out_valid_q <= 1'b0;
      count_q     <= pu_pkg::RESET_COUNT;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) count_q <= cfg_element_count_i;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    r_q       <= r_d;
    n_q       <= n_d;
    left_q    <= left_d;
    q_q       <= q_d;
    bit_q     <= bit_d;
    pool_q    <= pool_d;
    element_q <= element_d;
    last_q    <= last_d;
    bad_q     <= bad_d;
  end

endmodule

[rtl/pu_checker.sv]
// port-level checker for the permutation unranking block, with its bind
module pu_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic [pu_pkg::ELEM_W-1:0]  element_o,
  input logic                       last_o,
  input logic                       bad_rank_o,
  input logic                       cfg_valid_i,
  input logic                       cfg_ready_o
);

  // a stalled result transaction stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a flagged rank gives one zero element marked last
  a_bad_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_rank_o |-> last_o && (element_o == '0))
    else $error("bad rank result malformed");

  // elements stay inside the permutation range
  a_elem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> element_o < pu_pkg::ELEM_W'(pu_pkg::MAX_ELEMENTS))
    else $error("element out of range");

  // one rank at a time: busy right after a rank transaction
  a_busy_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o && !cfg_ready_o)
    else $error("not busy after rank transaction");

  // configuration is taken only while the block is idle
  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o |-> !in_stall_o)
    else $error("configuration taken while busy");

endmodule

bind permutation_unrank_top pu_checker u_pu_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .element_o   (element_o),
  .last_o      (last_o),
  .bad_rank_o  (bad_rank_o),
  .cfg_valid_i (cfg_valid_i),
  .cfg_ready_o (cfg_ready_o)
);

[verif/tb.sv]
// self-checking testbench for the permutation unranking block
`timescale 1ns / 1ps

module tb;

  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned LONG_HOLD      = 400;
  localparam int unsigned DRAIN_CYCLES   = 60;
  localparam int unsigned PHASE_ITEMS    = 27;

  // one element transaction as seen on the output side
  typedef struct packed {
    logic [pu_pkg::ELEM_W-1:0] element;
    logic                      last;
    logic                      bad_rank;
  } perm_elem_t;

  logic                        clk_i       = 1'b0;
  logic                        rst_ni      = 1'b0;
  logic                        in_valid    = 1'b0;
  logic                        in_stall_o;
  logic [pu_pkg::RANK_W-1:0]   rank        = '0;
  logic                        out_valid_o;
  logic                        out_stall   = 1'b0;
  logic [pu_pkg::ELEM_W-1:0]   element_o;
  logic                        last_o;
  logic                        bad_rank_o;
  logic                        cfg_valid   = 1'b0;
  logic                        cfg_ready_o;
  logic [pu_pkg::CNT_W-1:0]    cfg_count   = '0;

  logic [pu_pkg::RANK_W-1:0]   rank_queue[$];
  perm_elem_t                  expected_elems[$];
  logic [pu_pkg::CNT_W-1:0]    count_setting = pu_pkg::RESET_COUNT;
  int unsigned                 send_idle_pct = 0;
  int unsigned                 recv_idle_pct = 0;
  int unsigned                 hold_trigger  = 0;
  int unsigned                 hold_seen     = 0;
  int unsigned                 hold_left     = 0;
  int unsigned                 quiet_cycles  = 0;
  int unsigned                 error_count   = 0;

  permutation_unrank_top dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid),
    .in_stall_o          (in_stall_o),
    .rank_i              (rank),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall),
    .element_o           (element_o),
    .last_o              (last_o),
    .bad_rank_o          (bad_rank_o),
    .cfg_valid_i         (cfg_valid),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_element_count_i (cfg_count)
  );

  // clock
  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic longint unsigned factorial(int unsigned k);
    longint unsigned f;
    f = 1;
    for (int unsigned i = 2; i <= k; i++) f = f * i;
    return f;
  endfunction

  // register values outside 2..10 saturate
  function automatic int unsigned clamp_count(logic [pu_pkg::CNT_W-1:0] v);
    if (v < 2) return 2;
    if (v > pu_pkg::MAX_ELEMENTS) return pu_pkg::MAX_ELEMENTS;
    return int'(v);
  endfunction

  // expected element sequence for one accepted rank
  task automatic unrank_rank(logic [pu_pkg::RANK_W-1:0] r_in);
    int unsigned               n;
    int unsigned               left;
    int unsigned               q;
    longint unsigned           r;
    longint unsigned           f;
    logic [pu_pkg::ELEM_W-1:0] pool [pu_pkg::MAX_ELEMENTS];
    perm_elem_t                e;
    n = clamp_count(count_setting);
    r = 64'(r_in);
    if (r >= factorial(n)) begin
      e.element  = '0;
      e.last     = 1'b1;
      e.bad_rank = 1'b1;
      expected_elems.insert(expected_elems.size(), e);
      return;
    end
    for (int unsigned i = 0; i < n; i++) pool[i] = pu_pkg::ELEM_W'(i);
    left = n;
    for (int unsigned pos = 0; pos < n; pos++) begin
      f = factorial(left - 1);
      q = int'(r / f);
      r = r % f;
      if (q >= left) q = left - 1;
      e.element  = pool[q];
      e.last     = (pos + 1 == n);
      e.bad_rank = 1'b0;
      expected_elems.insert(expected_elems.size(), e);
      for (int unsigned i = q; i + 1 < left; i++) pool[i] = pool[i + 1];
      left--;
    end
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    error_count++;
  endtask

  // rank driver: holds the payload while stalled
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      rank     <= '0;
    end else begin
      if (in_valid && !in_stall_o) unrank_rank(rank);
      if (!in_valid || !in_stall_o) begin
        if (rank_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          rank     <= rank_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // element monitor and receiver stall generation
  always @(posedge clk_i or negedge rst_ni) begin
    perm_elem_t want;
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall) begin
        if (expected_elems.size() == 0) begin
          report_mismatch("unexpected element transaction", 32'(element_o), 32'd0);
        end else begin
          want = expected_elems.pop_front();
          if (element_o !== want.element)
            report_mismatch("element", 32'(element_o), 32'(want.element));
          if (last_o !== want.last)
            report_mismatch("last", 32'(last_o), 32'(want.last));
          if (bad_rank_o !== want.bad_rank)
            report_mismatch("bad_rank", 32'(bad_rank_o), 32'(want.bad_rank));
        end
      end
      // long hold-off on request, otherwise random stalls
      if (hold_seen != hold_trigger) begin
        hold_seen = hold_trigger;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // watchdog on cycles without any accepted transaction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall) ||
          (cfg_valid && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic wait_idle();
    @(negedge clk_i);
    while (rank_queue.size() > 0 || in_valid || expected_elems.size() > 0) @(negedge clk_i);
  endtask

  task automatic write_count(logic [pu_pkg::CNT_W-1:0] v);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_count <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid     <= 1'b0;
    count_setting = v;
  endtask

  // idle block, then new idling mode and register setting
  task automatic start_phase(logic [pu_pkg::CNT_W-1:0] v, int unsigned mode);
    wait_idle();
    case (mode)
      0: begin
        send_idle_pct = 15;
        recv_idle_pct = 86;
      end
      1: begin
        send_idle_pct = 86;
        recv_idle_pct = 15;
      end
      default: begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    endcase
    write_count(v);
    @(negedge clk_i);
  endtask

  // mostly legal ranks, some out of range, some fully random
  function automatic logic [pu_pkg::RANK_W-1:0] pick_rank(logic [pu_pkg::CNT_W-1:0] v);
    int unsigned     sel;
    longint unsigned fmax;
    sel  = $urandom_range(99);
    fmax = factorial(clamp_count(v));
    if (sel < 8)
      return pu_pkg::RANK_W'($urandom_range((1 << pu_pkg::RANK_W) - 1, int'(fmax)));
    if (sel < 11) return pu_pkg::RANK_W'($urandom);
    return pu_pkg::RANK_W'($urandom_range(int'(fmax - 1), 0));
  endfunction

  // stimulus sequence
  initial begin
    logic [pu_pkg::CNT_W-1:0] phase_counts [16];
    phase_counts = '{4'd10, 4'd4, 4'd12, 4'd7, 4'd2, 4'd9, 4'd10, 4'd5,
                     4'd14, 4'd8, 4'd3, 4'd6, 4'd10, 4'd0, 4'd1, 4'd15};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // full length: edges of the legal range, first illegal rank, all ones
    start_phase(4'd10, 0);
    rank_queue = '{22'd0, 22'd3628799, 22'd3628800, 22'h3FFFFF, 22'd1, 22'd362880,
                   22'd2097152};
    // shortest permutation and the counts that saturate to it
    start_phase(4'd2, 0);
    rank_queue = '{22'd0, 22'd1, 22'd2};
    start_phase(4'd0, 0);
    rank_queue = '{22'd0, 22'd1, 22'd2};
    start_phase(4'd1, 0);
    rank_queue = '{22'd1, 22'd2};
    // counts above the maximum saturate to ten
    start_phase(4'd15, 0);
    rank_queue = '{22'd3628799, 22'd3628800};
    start_phase(4'd11, 0);
    rank_queue = '{22'd5};
    start_phase(4'd3, 0);
    rank_queue = '{22'd5, 22'd6};

    // random phases, idling mode moves across the run
    for (int unsigned p = 0; p < 16; p++) begin
      start_phase(phase_counts[p], p * 3 / 16);
      for (int unsigned i = 0; i < PHASE_ITEMS; i++)
        rank_queue.insert(rank_queue.size(), pick_rank(phase_counts[p]));
      if (p == 0 || p == 12) hold_trigger++;
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
